@@ rtl/cnfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnfp_pkg
// Shared types and codes of the CNF token stream parser: token kinds, event
// and error codes, beat structs and the clause buffer geometry.
// ----------------------------------------------------------------------------
package cnfp_pkg;

    localparam int MAX_LITS  = 32;
    localparam int LIT_IDX_W = (MAX_LITS > 1) ? $clog2(MAX_LITS) : 1;
    localparam int LIT_CNT_W = $clog2(MAX_LITS + 1);

    localparam logic [2:0] TOK_COMMENT  = 3'd0;
    localparam logic [2:0] TOK_P        = 3'd1;
    localparam logic [2:0] TOK_NUM      = 3'd2;
    localparam logic [2:0] TOK_ZERO     = 3'd3;
    localparam logic [2:0] TOK_NEWLINE  = 3'd4;
    localparam logic [2:0] TOK_EOF      = 3'd5;
    localparam logic [2:0] TOK_SCAN_ERR = 3'd6;
    localparam logic [2:0] TOK_UNUSED   = 3'd7;

    localparam logic [1:0] EVT_HEADER  = 2'd0;
    localparam logic [1:0] EVT_LITERAL = 2'd1;
    localparam logic [1:0] EVT_DONE    = 2'd2;
    localparam logic [1:0] EVT_ERROR   = 2'd3;

    localparam logic [2:0] ERR_SCANNER     = 3'd0;
    localparam logic [2:0] ERR_DUP_HEADER  = 3'd1;
    localparam logic [2:0] ERR_NO_HEADER   = 3'd2;
    localparam logic [2:0] ERR_HDR_SYNTAX  = 3'd3;
    localparam logic [2:0] ERR_CLS_SYNTAX  = 3'd4;
    localparam logic [2:0] ERR_CLS_TOO_LONG = 3'd5;

    typedef struct packed {
        logic [2:0]         token_kind;
        logic signed [31:0] token_value;
    } cnfp_tok_t;

    typedef struct packed {
        logic [1:0]         event_res;
        logic signed [31:0] literal;
        logic               last_literal;
        logic [30:0]        declared_vars;
        logic [30:0]        declared_clauses;
        logic [31:0]        clauses_seen;
        logic [30:0]        largest_var;
        logic [2:0]         error_code;
        logic               warn_vars_exceeded;
        logic               warn_fewer_clauses;
        logic               warn_more_clauses;
    } cnfp_evt_t;

    typedef struct packed {
        logic                 en;
        logic [LIT_IDX_W-1:0] addr;
        logic signed [31:0]   data;
    } cnfp_wr_t;

endpackage
`default_nettype wire

@@ rtl/cnfp_lit_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnfp_lit_store
// Clause literal buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cnfp_lit_store (
    input  logic                            clk,
    input  cnfp_pkg::cnfp_wr_t              wr,
    input  logic [cnfp_pkg::LIT_IDX_W-1:0]  rd_addr,
    output logic signed [31:0]              rd_data
);
    import cnfp_pkg::*;

    logic signed [31:0] mem [MAX_LITS];
    logic signed [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/cnfp_parse.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnfp_parse
// Token sequencer: header checks, clause bookkeeping, readout of the literal
// buffer and the event output register.
// ----------------------------------------------------------------------------
module cnfp_parse (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tok_valid,
    output logic                            tok_stall,
    input  cnfp_pkg::cnfp_tok_t             tok,
    output logic                            evt_valid,
    input  logic                            evt_stall,
    output cnfp_pkg::cnfp_evt_t             evt,
    output cnfp_pkg::cnfp_wr_t              lit_wr,
    output logic [cnfp_pkg::LIT_IDX_W-1:0]  lit_rd_addr,
    input  logic signed [31:0]              lit_rd_data
);
    import cnfp_pkg::*;

    typedef enum logic [2:0] {
        PH_INIT, PH_P1, PH_P2, PH_P3, PH_B1, PH_B2, PH_B3, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        CTL_IDLE, CTL_EMIT, CTL_DONE
    } ctl_t;

    phase_t                 phase_reg, phase_next;
    ctl_t                   ctl_reg, ctl_next;
    logic [30:0]            hdr_vars_reg, hdr_vars_next;
    logic [30:0]            hdr_clauses_reg, hdr_clauses_next;
    logic [30:0]            max_var_reg, max_var_next;
    logic [31:0]            clause_total_reg, clause_total_next;
    logic [LIT_CNT_W-1:0]   lit_count_reg, lit_count_next;
    logic [LIT_CNT_W-1:0]   emit_idx_reg, emit_idx_next;
    logic                   done_pend_reg, done_pend_next;
    logic                   evt_valid_reg, evt_valid_next;
    cnfp_evt_t              evt_reg, evt_next;

    logic                   out_free;
    logic                   tok_acc;
    logic [31:0]            tok_u;
    logic [31:0]            tok_mag32;
    logic [30:0]            tok_mag;
    logic                   emit_last;
    logic                   evt_ld;
    cnfp_evt_t              evt_new;
    cnfp_evt_t              done_evt;
    logic                   err_hit;
    logic [2:0]             err_code;
    logic                   close_cls;

    assign out_free  = !evt_valid_reg || !evt_stall;
    assign tok_stall = !((ctl_reg == CTL_IDLE) && out_free);
    assign tok_acc   = tok_valid && !tok_stall;

    // magnitude, most negative value clamps to the 31-bit maximum
    assign tok_u     = tok.token_value;
    assign tok_mag32 = tok_u[31] ? (32'd0 - tok_u) : tok_u;
    assign tok_mag   = tok_mag32[31] ? 31'h7FFF_FFFF : tok_mag32[30:0];

    assign emit_last = (emit_idx_reg + LIT_CNT_W'(1)) == lit_count_reg;

    always_comb
    begin
        done_evt                    = '0;
        done_evt.event_res          = EVT_DONE;
        done_evt.declared_vars      = hdr_vars_reg;
        done_evt.declared_clauses   = hdr_clauses_reg;
        done_evt.clauses_seen       = clause_total_reg;
        done_evt.largest_var        = max_var_reg;
        done_evt.warn_vars_exceeded = hdr_vars_reg < max_var_reg;
        done_evt.warn_fewer_clauses = {1'b0, hdr_clauses_reg} > clause_total_reg;
        done_evt.warn_more_clauses  = {1'b0, hdr_clauses_reg} < clause_total_reg;
    end

    always_comb
    begin
        phase_next        = phase_reg;
        ctl_next          = ctl_reg;
        hdr_vars_next     = hdr_vars_reg;
        hdr_clauses_next  = hdr_clauses_reg;
        max_var_next      = max_var_reg;
        clause_total_next = clause_total_reg;
        lit_count_next    = lit_count_reg;
        emit_idx_next     = emit_idx_reg;
        done_pend_next    = done_pend_reg;
        evt_ld            = 1'b0;
        evt_new           = '0;
        err_hit           = 1'b0;
        err_code          = ERR_SCANNER;
        close_cls         = 1'b0;
        lit_wr            = '0;
        lit_wr.addr       = lit_count_reg[LIT_IDX_W-1:0];
        lit_wr.data       = tok.token_value;

        case (ctl_reg)
            CTL_IDLE:
            begin
                if (tok_acc && (phase_reg != PH_DONE))
                begin
                    if (tok.token_kind inside {TOK_SCAN_ERR, TOK_UNUSED})
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_SCANNER;
                    end
                    else if (tok.token_kind != TOK_COMMENT)
                    begin
                        case (phase_reg)
                            PH_INIT:
                            begin
                                if (tok.token_kind == TOK_P)
                                begin
                                    phase_next = PH_P1;
                                end
                                else if (tok.token_kind == TOK_EOF)
                                begin
                                    err_hit  = 1'b1;
                                    err_code = ERR_NO_HEADER;
                                end
                            end
                            PH_P1, PH_P2:
                            begin
                                if ((tok.token_kind != TOK_NUM) || tok_u[31])
                                begin
                                    err_hit  = 1'b1;
                                    err_code = ERR_HDR_SYNTAX;
                                end
                                else if (phase_reg == PH_P1)
                                begin
                                    hdr_vars_next = tok_u[30:0];
                                    phase_next    = PH_P2;
                                end
                                else
                                begin
                                    hdr_clauses_next = tok_u[30:0];
                                    phase_next       = PH_P3;
                                end
                            end
                            PH_P3:
                            begin
                                if (tok.token_kind != TOK_NEWLINE)
                                begin
                                    err_hit  = 1'b1;
                                    err_code = ERR_HDR_SYNTAX;
                                end
                                else
                                begin
                                    evt_ld                   = 1'b1;
                                    evt_new.event_res        = EVT_HEADER;
                                    evt_new.declared_vars    = hdr_vars_reg;
                                    evt_new.declared_clauses = hdr_clauses_reg;
                                    phase_next               = PH_B1;
                                end
                            end
                            PH_B1:
                            begin
                                case (tok.token_kind)
                                    TOK_P:
                                    begin
                                        err_hit  = 1'b1;
                                        err_code = ERR_DUP_HEADER;
                                    end
                                    TOK_EOF:
                                    begin
                                        evt_ld     = 1'b1;
                                        evt_new    = done_evt;
                                        phase_next = PH_DONE;
                                    end
                                    TOK_NEWLINE:
                                    begin
                                    end
                                    TOK_NUM:
                                    begin
                                        lit_wr.en      = 1'b1;
                                        lit_count_next = LIT_CNT_W'(1);
                                        if (tok_mag > max_var_reg)
                                        begin
                                            max_var_next = tok_mag;
                                        end
                                        phase_next = PH_B2;
                                    end
                                    default:
                                    begin
                                        err_hit  = 1'b1;
                                        err_code = ERR_CLS_SYNTAX;
                                    end
                                endcase
                            end
                            PH_B2:
                            begin
                                case (tok.token_kind)
                                    TOK_ZERO:
                                    begin
                                        phase_next = PH_B3;
                                    end
                                    TOK_NEWLINE:
                                    begin
                                    end
                                    TOK_NUM:
                                    begin
                                        if (lit_count_reg >= LIT_CNT_W'(MAX_LITS))
                                        begin
                                            err_hit  = 1'b1;
                                            err_code = ERR_CLS_TOO_LONG;
                                        end
                                        else
                                        begin
                                            lit_wr.en      = 1'b1;
                                            lit_count_next = lit_count_reg + LIT_CNT_W'(1);
                                            if (tok_mag > max_var_reg)
                                            begin
                                                max_var_next = tok_mag;
                                            end
                                        end
                                    end
                                    default:
                                    begin
                                        err_hit  = 1'b1;
                                        err_code = ERR_CLS_SYNTAX;
                                    end
                                endcase
                            end
                            PH_B3:
                            begin
                                if (tok.token_kind == TOK_NEWLINE)
                                begin
                                    close_cls  = 1'b1;
                                    phase_next = PH_B1;
                                end
                                else if (tok.token_kind == TOK_EOF)
                                begin
                                    close_cls      = 1'b1;
                                    done_pend_next = 1'b1;
                                    phase_next     = PH_DONE;
                                end
                                else
                                begin
                                    err_hit  = 1'b1;
                                    err_code = ERR_CLS_SYNTAX;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            CTL_EMIT:
            begin
                if (out_free)
                begin
                    evt_ld               = 1'b1;
                    evt_new.event_res    = EVT_LITERAL;
                    evt_new.literal      = lit_rd_data;
                    evt_new.last_literal = emit_last;
                    emit_idx_next        = emit_idx_reg + LIT_CNT_W'(1);
                    if (emit_last)
                    begin
                        lit_count_next = '0;
                        ctl_next       = done_pend_reg ? CTL_DONE : CTL_IDLE;
                    end
                end
            end
            CTL_DONE:
            begin
                if (out_free)
                begin
                    evt_ld         = 1'b1;
                    evt_new        = done_evt;
                    done_pend_next = 1'b0;
                    ctl_next       = CTL_IDLE;
                end
            end
            default:
            begin
                ctl_next = CTL_IDLE;
            end
        endcase

        if (close_cls)
        begin
            if (clause_total_reg != 32'hFFFF_FFFF)
            begin
                clause_total_next = clause_total_reg + 32'd1;
            end
            emit_idx_next = '0;
            ctl_next      = CTL_EMIT;
        end

        if (err_hit)
        begin
            evt_ld             = 1'b1;
            evt_new            = '0;
            evt_new.event_res  = EVT_ERROR;
            evt_new.error_code = err_code;
            phase_next         = PH_DONE;
        end

        evt_valid_next = evt_ld ? 1'b1 : (evt_valid_reg && evt_stall);
        evt_next       = evt_ld ? evt_new : evt_reg;
    end

    // during a readout, read data shows the entry at emit_idx_reg
    assign lit_rd_addr = emit_idx_next[LIT_IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_INIT;
            ctl_reg          <= CTL_IDLE;
            hdr_vars_reg     <= '0;
            hdr_clauses_reg  <= '0;
            max_var_reg      <= '0;
            clause_total_reg <= '0;
            lit_count_reg    <= '0;
            emit_idx_reg     <= '0;
            done_pend_reg    <= 1'b0;
            evt_valid_reg    <= 1'b0;
            evt_reg          <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            ctl_reg          <= ctl_next;
            hdr_vars_reg     <= hdr_vars_next;
            hdr_clauses_reg  <= hdr_clauses_next;
            max_var_reg      <= max_var_next;
            clause_total_reg <= clause_total_next;
            lit_count_reg    <= lit_count_next;
            emit_idx_reg     <= emit_idx_next;
            done_pend_reg    <= done_pend_next;
            evt_valid_reg    <= evt_valid_next;
            evt_reg          <= evt_next;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule
`default_nettype wire

@@ rtl/cnf_token_stream_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnf_token_stream_parser
// DIMACS CNF parser working on a stream of scanned tokens.
//
// Token channel (tok_valid / tok_stall / tok): one scanned token per beat.
// Event channel (evt_valid / evt_stall / evt): header, clause literal, done
// and error events. A beat moves when valid is high and stall is low.
// Header and error events, and a done event on end of file outside a clause,
// appear in the cycle after the token that causes them. Number tokens are
// written to the literal buffer as they are taken. The token that closes a
// clause starts a readout of the buffer: the first literal beat passes the
// buffer read register and then the event register, then one literal per
// cycle follows while the event side takes them, and on end of file a done
// beat after the last literal. Tokens are not taken during a readout.
// A single event register sits between the channels: a token is taken while
// an event waits, as long as that event leaves in the same cycle.
// While an event beat is held by evt_stall, the event register holds and
// tok_stall rises.
// Reset puts the parser back to waiting for the header with all counts
// zero. After a done or error event all tokens are taken and dropped until
// the next reset.
// ----------------------------------------------------------------------------
module cnf_token_stream_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tok_valid,
    output logic                   tok_stall,
    input  cnfp_pkg::cnfp_tok_t    tok,
    output logic                   evt_valid,
    input  logic                   evt_stall,
    output cnfp_pkg::cnfp_evt_t    evt
);
    import cnfp_pkg::*;

    cnfp_wr_t               lit_wr;
    logic [LIT_IDX_W-1:0]   lit_rd_addr;
    logic signed [31:0]     lit_rd_data;

    cnfp_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok_valid   (tok_valid),
        .tok_stall   (tok_stall),
        .tok         (tok),
        .evt_valid   (evt_valid),
        .evt_stall   (evt_stall),
        .evt         (evt),
        .lit_wr      (lit_wr),
        .lit_rd_addr (lit_rd_addr),
        .lit_rd_data (lit_rd_data)
    );

    cnfp_lit_store u_lit_store (
        .clk     (clk),
        .wr      (lit_wr),
        .rd_addr (lit_rd_addr),
        .rd_data (lit_rd_data)
    );

endmodule
`default_nettype wire

@@ rtl/cnfp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnfp_checker
// Port-level checks of the CNF token stream parser, bound to the top level.
// ----------------------------------------------------------------------------
module cnfp_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tok_stall,
    input  logic                   evt_valid,
    input  logic                   evt_stall,
    input  cnfp_pkg::cnfp_evt_t    evt
);
    import cnfp_pkg::*;

    logic evt_acc;
    assign evt_acc = evt_valid && !evt_stall;

    // stalled beat holds
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_stall |=> evt_valid && $stable(evt))
        else $error("event beat changed under stall");

    // parse is finished after a done or error beat leaves
    a_final_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        evt_acc && ((evt.event_res == EVT_DONE) || (evt.event_res == EVT_ERROR))
        |=> !evt_valid)
        else $error("event after end of parse");

    // no token taken in the middle of a clause readout
    a_readout_block: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt.event_res == EVT_LITERAL) && !evt.last_literal
        |-> tok_stall)
        else $error("token taken during clause readout");

    a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt.event_res == EVT_HEADER)
        |-> (evt.literal == 0) && (evt.clauses_seen == 0) && !evt.last_literal)
        else $error("header event carries clause fields");

endmodule

bind cnf_token_stream_parser cnfp_checker u_cnfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_stall (tok_stall),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
);
`default_nettype wire

@@ dv/cnf_token_stream_parser_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnf_token_stream_parser_test
// Self-checking bench for the CNF token stream parser. A short table of
// hand-picked tokens (ignored tokens before the header, header, extreme
// literals, split clauses) is followed by random clauses and one random way
// to end the parse: end of file or an error path; some runs end at once on a
// header fault. Each event beat is compared in full with a behavioral copy
// of the parser or a hand-written one. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module cnf_token_stream_parser_test;

    import cnfp_pkg::*;

    typedef enum logic [2:0] {
        PH_WAIT_P,
        PH_VARS,
        PH_CLAUSES,
        PH_HDR_NL,
        PH_CLS_START,
        PH_CLS_BODY,
        PH_CLS_ZERO,
        PH_FINISHED
    } parse_phase_t;

    typedef struct {
        cnfp_tok_t tok;
        bit        typed;
        cnfp_evt_t evt;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       tok_valid = 1'b0;
    logic       tok_stall;
    cnfp_tok_t  tok = '0;
    logic       evt_valid;
    logic       evt_stall = 1'b0;
    cnfp_evt_t  evt;

    bit         tok_calm = 1'b0;
    bit         evt_calm = 1'b0;
    int         tokens_sent = 0;
    int         mismatch_cnt = 0;

    // parser model state, reset values
    parse_phase_t phase = PH_WAIT_P;
    logic [30:0]  decl_vars = '0;
    logic [30:0]  decl_clauses = '0;
    logic [30:0]  top_var = '0;
    logic [31:0]  clause_cnt = '0;
    logic [31:0]  lit_buf [MAX_LITS];
    int           lit_cnt = 0;

    cnfp_evt_t    pending_events [$];
    dir_row_t     dir_rows [$];

    cnf_token_stream_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic void queue_event(cnfp_evt_t e);
        pending_events = {pending_events, e};
    endfunction

    function automatic void push_error(logic [2:0] code);
        cnfp_evt_t e;
        e = '0;
        e.event_res  = EVT_ERROR;
        e.error_code = code;
        queue_event(e);
        phase = PH_FINISHED;
    endfunction

    function automatic void note_magnitude(logic [31:0] v);
        logic [31:0] mag;
        mag = v[31] ? (32'd0 - v) : v;
        if (mag > 32'h7FFF_FFFF)
            mag = 32'h7FFF_FFFF;
        if (mag[30:0] > top_var)
            top_var = mag[30:0];
    endfunction

    function automatic void flush_clause();
        cnfp_evt_t e;
        for (int i = 0; i < lit_cnt; i++)
        begin
            e = '0;
            e.event_res    = EVT_LITERAL;
            e.literal      = lit_buf[i];
            e.last_literal = (i == lit_cnt - 1);
            queue_event(e);
        end
        if (clause_cnt != 32'hFFFF_FFFF)
            clause_cnt++;
        lit_cnt = 0;
    endfunction

    function automatic void push_done();
        cnfp_evt_t e;
        e = '0;
        e.event_res          = EVT_DONE;
        e.declared_vars      = decl_vars;
        e.declared_clauses   = decl_clauses;
        e.clauses_seen       = clause_cnt;
        e.largest_var        = top_var;
        e.warn_vars_exceeded = (decl_vars < top_var);
        e.warn_fewer_clauses = ({1'b0, decl_clauses} > clause_cnt);
        e.warn_more_clauses  = ({1'b0, decl_clauses} < clause_cnt);
        queue_event(e);
        phase = PH_FINISHED;
    endfunction

    function automatic void parse_token(cnfp_tok_t t);
        cnfp_evt_t e;
        logic [2:0] k;
        logic [31:0] v;
        k = t.token_kind;
        v = t.token_value;
        if (phase == PH_FINISHED)
            return;
        if (k == TOK_SCAN_ERR || k == TOK_UNUSED)
        begin
            push_error(ERR_SCANNER);
            return;
        end
        if (k == TOK_COMMENT)
            return;
        case (phase)
            PH_WAIT_P:
                if (k == TOK_P)
                    phase = PH_VARS;
                else if (k == TOK_EOF)
                    push_error(ERR_NO_HEADER);
            PH_VARS, PH_CLAUSES:
                if (k != TOK_NUM || v[31])
                    push_error(ERR_HDR_SYNTAX);
                else if (phase == PH_VARS)
                begin
                    decl_vars = v[30:0];
                    phase = PH_CLAUSES;
                end
                else
                begin
                    decl_clauses = v[30:0];
                    phase = PH_HDR_NL;
                end
            PH_HDR_NL:
                if (k != TOK_NEWLINE)
                    push_error(ERR_HDR_SYNTAX);
                else
                begin
                    e = '0;
                    e.event_res        = EVT_HEADER;
                    e.declared_vars    = decl_vars;
                    e.declared_clauses = decl_clauses;
                    queue_event(e);
                    phase = PH_CLS_START;
                end
            PH_CLS_START:
                if (k == TOK_P)
                    push_error(ERR_DUP_HEADER);
                else if (k == TOK_EOF)
                    push_done();
                else if (k == TOK_NUM)
                begin
                    lit_buf[0] = v;
                    lit_cnt = 1;
                    note_magnitude(v);
                    phase = PH_CLS_BODY;
                end
                else if (k != TOK_NEWLINE)
                    push_error(ERR_CLS_SYNTAX);
            PH_CLS_BODY:
                if (k == TOK_ZERO)
                    phase = PH_CLS_ZERO;
                else if (k == TOK_NUM)
                begin
                    if (lit_cnt >= MAX_LITS)
                        push_error(ERR_CLS_TOO_LONG);
                    else
                    begin
                        lit_buf[lit_cnt] = v;
                        lit_cnt++;
                        note_magnitude(v);
                    end
                end
                else if (k != TOK_NEWLINE)
                    push_error(ERR_CLS_SYNTAX);
            default:
                if (k == TOK_NEWLINE)
                begin
                    flush_clause();
                    phase = PH_CLS_START;
                end
                else if (k == TOK_EOF)
                begin
                    flush_clause();
                    push_done();
                end
                else
                    push_error(ERR_CLS_SYNTAX);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Event checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cnfp_evt_t want;
        if (rst_n && evt_valid === 1'b1 && evt_stall === 1'b0)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: event beat with nothing expected, expected none got %h",
                         $time, evt);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (evt !== want)
                begin
                    $display("%0t: event beat expected %h got %h", $time, want, evt);
                    mismatch_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Traffic shaping: stretches of full-rate traffic now and then
    // ------------------------------------------------------------------------
    always
    begin
        repeat ($urandom_range(100, 400)) @(posedge clk);
        tok_calm <= ($urandom_range(0, 3) == 0);
        evt_calm <= ($urandom_range(0, 3) == 0);
    end

    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = evt_calm ? 0 : $urandom_range(0, 19);
            if (hold != 0)
            begin
                evt_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            evt_stall <= 1'b0;
            do @(posedge clk); while (evt_valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------------
    // Token driving
    // ------------------------------------------------------------------------
    function automatic cnfp_tok_t make_token(logic [2:0] k, logic [31:0] v);
        cnfp_tok_t t;
        t.token_kind  = k;
        t.token_value = v;
        return t;
    endfunction

    task automatic send_token(cnfp_tok_t t, bit typed, cnfp_evt_t typed_evt);
        int gap;
        gap = tok_calm ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            tok_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tok_valid <= 1'b1;
        tok <= t;
        do @(posedge clk); while (tok_stall !== 1'b0);
        tokens_sent++;
        parse_token(t);
        // hand-written expectation replaces the modeled one for this beat
        if (typed)
            pending_events[pending_events.size() - 1] = typed_evt;
    endtask

    task automatic put_token(logic [2:0] k, logic [31:0] v);
        send_token(make_token(k, v), 1'b0, '0);
    endtask

    task automatic wait_drained();
        tok_valid <= 1'b0;
        do @(posedge clk); while (pending_events.size() != 0);
    endtask

    function automatic void add_row(logic [2:0] k, logic [31:0] v, bit typed = 1'b0,
                                    cnfp_evt_t e = '0);
        dir_row_t r;
        r.tok   = make_token(k, v);
        r.typed = typed;
        r.evt   = e;
        dir_rows = {dir_rows, r};
    endfunction

    function automatic logic [31:0] rand_literal();
        int r;
        logic [31:0] mag;
        r = $urandom_range(0, 99);
        if (r < 2)
            return 32'd0;
        if (r < 12)
            return $urandom;
        mag = $urandom_range(1, 48);
        return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
    endfunction

    task automatic send_clause(int len);
        for (int i = 0; i < len; i++)
        begin
            put_token(TOK_NUM, rand_literal());
            if ($urandom_range(0, 9) == 0)
                put_token($urandom_range(0, 1) ? TOK_NEWLINE : TOK_COMMENT, $urandom);
        end
        put_token(TOK_ZERO, $urandom);
        if ($urandom_range(0, 9) == 0)
            put_token(TOK_COMMENT, $urandom);
        put_token(TOK_NEWLINE, $urandom);
        if ($urandom_range(0, 7) == 0)
            put_token(TOK_NEWLINE, $urandom);
    endtask

    initial
    begin
        logic [30:0] hdr_vars;
        logic [30:0] hdr_clauses;
        cnfp_evt_t   hdr_evt;
        cnfp_evt_t   neg_evt;
        int          len;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        if ($urandom_range(0, 7) == 0)
        begin
            // header faults finish the parse at once, so one per run
            put_token(TOK_NUM, $urandom);
            case ($urandom_range(0, 4))
                0: put_token(TOK_EOF, $urandom);
                1:
                begin
                    put_token(TOK_P, $urandom);
                    put_token(TOK_NUM, 32'h8000_0000 | $urandom);
                end
                2:
                begin
                    put_token(TOK_P, $urandom);
                    put_token(TOK_NUM, 32'd7);
                    put_token(TOK_ZERO, $urandom);
                end
                3:
                begin
                    put_token(TOK_P, $urandom);
                    put_token(TOK_NUM, 32'd3);
                    put_token(TOK_NUM, 32'd4);
                    put_token(TOK_NUM, 32'd9);
                end
                default:
                begin
                    put_token(TOK_P, $urandom);
                    put_token(TOK_NEWLINE, $urandom);
                end
            endcase
            wait_drained();
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: hdr_vars = 31'h7FFF_FFFF;
                1: hdr_vars = 31'h7FFF_FFFE;
                default: hdr_vars = 31'($urandom_range(1, 60));
            endcase
            hdr_clauses = 31'($urandom_range(0, 45));

            hdr_evt = '0;
            hdr_evt.event_res        = EVT_HEADER;
            hdr_evt.declared_vars    = hdr_vars;
            hdr_evt.declared_clauses = hdr_clauses;
            neg_evt = '0;
            neg_evt.event_res    = EVT_LITERAL;
            neg_evt.literal      = 32'h8000_0000;
            neg_evt.last_literal = 1'b1;

            // ignored before the header
            add_row(TOK_COMMENT, 32'hFFFF_FFFF);
            add_row(TOK_NUM, 32'd5);
            add_row(TOK_ZERO, 32'd0);
            add_row(TOK_NEWLINE, 32'd0);
            add_row(TOK_P, 32'd0);
            add_row(TOK_COMMENT, 32'd0);
            add_row(TOK_NUM, {1'b0, hdr_vars});
            add_row(TOK_NUM, {1'b0, hdr_clauses});
            add_row(TOK_NEWLINE, 32'd0, 1'b1, hdr_evt);
            add_row(TOK_NEWLINE, 32'd0);
            add_row(TOK_COMMENT, 32'd0);
            // most negative literal: emitted as is, magnitude clipped
            add_row(TOK_NUM, 32'h8000_0000);
            add_row(TOK_ZERO, 32'd0);
            add_row(TOK_NEWLINE, 32'd0, 1'b1, neg_evt);
            add_row(TOK_NUM, 32'h7FFF_FFFF);
            add_row(TOK_NUM, 32'h8000_0001);
            add_row(TOK_NEWLINE, 32'd0);
            add_row(TOK_COMMENT, 32'd0);
            add_row(TOK_NUM, 32'hFFFF_FFFF);
            add_row(TOK_NUM, 32'd1);
            add_row(TOK_ZERO, 32'hFFFF_FFFF);
            add_row(TOK_NEWLINE, 32'd0);

            foreach (dir_rows[i])
                send_token(dir_rows[i].tok, dir_rows[i].typed, dir_rows[i].evt);
            wait_drained();

            while (tokens_sent < 160)
            begin
                case ($urandom_range(0, 19))
                    0: len = MAX_LITS;
                    1: len = $urandom_range(7, MAX_LITS - 1);
                    default: len = $urandom_range(1, 6);
                endcase
                send_clause(len);
                if ($urandom_range(0, 5) == 0)
                    wait_drained();
            end

            case ($urandom_range(0, 6))
                0:
                begin
                    // clause closed by end of file: literals, then done
                    len = ($urandom_range(0, 3) == 0) ? MAX_LITS : $urandom_range(1, 8);
                    repeat (len) put_token(TOK_NUM, rand_literal());
                    put_token(TOK_ZERO, $urandom);
                    put_token(TOK_EOF, $urandom);
                end
                1: put_token(TOK_EOF, $urandom);
                2: put_token(TOK_SCAN_ERR, $urandom);
                3: put_token(TOK_UNUSED, $urandom);
                4: put_token(TOK_P, $urandom);
                5:
                    case ($urandom_range(0, 2))
                        0: put_token(TOK_ZERO, $urandom);
                        1:
                        begin
                            put_token(TOK_NUM, rand_literal());
                            put_token(TOK_EOF, $urandom);
                        end
                        default:
                        begin
                            put_token(TOK_NUM, rand_literal());
                            put_token(TOK_ZERO, $urandom);
                            put_token(TOK_NUM, 32'd5);
                        end
                    endcase
                default: repeat (MAX_LITS + 1) put_token(TOK_NUM, rand_literal());
            endcase
        end

        // parse is finished: everything below must be dropped silently
        repeat (8) put_token(3'($urandom_range(0, 7)), $urandom);
        while (tokens_sent < 160)
            put_token(3'($urandom_range(0, 7)), $urandom);
        tok_valid <= 1'b0;

        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
